FILE: rtl/three_wire_spi_register_master_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef THREE_WIRE_SPI_REGISTER_MASTER_UNIT_DEFINES_SVH
`define THREE_WIRE_SPI_REGISTER_MASTER_UNIT_DEFINES_SVH

// cond and prop in the same cycle
`define TW3_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// cond now, prop in the cycle after
`define TW3_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/tw3_pkg.sv
package tw3_pkg;

   localparam int MAX_FRAME_BITS_DEF = 31;
   localparam int VAL_W = 30;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;

   localparam logic [4:0]  ADDR_WIDTH_RST = 5'd8;
   localparam logic [4:0]  DATA_WIDTH_RST = 5'd16;
   localparam logic [15:0] HALF_TICKS_RST = 16'd1;
   localparam logic [15:0] LEAD_TICKS_RST = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDR_WIDTH = 2'd0,
      CSR_DATA_WIDTH = 2'd1,
      CSR_HALF_TICKS = 2'd2,
      CSR_LEAD_TICKS = 2'd3
   } csr_idx_type;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ADDR_WIDE  = 2'd1,
      ST_VALUE_WIDE = 2'd2,
      ST_WIDTHS_BIG = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEAD = 3'd1,
      PH_DLO  = 3'd2,
      PH_DHI  = 3'd3,
      PH_SLO  = 3'd4,
      PH_SHI  = 3'd5,
      PH_RLO  = 3'd6,
      PH_RHI  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [4:0]  addr_bits;
      logic [4:0]  data_bits;
      logic [15:0] half_period_ticks;
      logic [15:0] lead_ticks;
   } cfg_type;

   typedef struct packed {
      logic             start_req;
      logic             mode;
      logic [VAL_W-1:0] reg_addr;
      logic [VAL_W-1:0] write_value;
      logic             line_in;
   } req_type;

   typedef struct packed {
      logic             select_pin;
      logic             clock_pin;
      logic             line_out;
      logic             line_drive;
      logic             busy_res;
      logic             done_res;
      status_type       status;
      logic [VAL_W-1:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       refuse;
      status_type status;
   } chk_type;

endpackage

FILE: rtl/tw3_req_check.sv
module tw3_req_check #(
   parameter int MAX_FRAME_BITS = tw3_pkg::MAX_FRAME_BITS_DEF,
   parameter int SO_W = MAX_FRAME_BITS + 1,
   parameter int BCNT_W = $clog2(MAX_FRAME_BITS + 2)
) (
   input  tw3_pkg::cfg_type    cfg,
   input  tw3_pkg::req_type    req,
   output tw3_pkg::chk_type    chk,
   output logic [SO_W-1:0]     frame,
   output logic [BCNT_W-1:0]   frame_bits
);
   import tw3_pkg::*;

   logic [5:0] wsum;
   logic       too_wide;
   logic       addr_over;
   logic       val_over;

   always_comb begin
      wsum = {1'b0, cfg.addr_bits} + {1'b0, cfg.data_bits};
      too_wide = (32'(cfg.addr_bits) >= MAX_FRAME_BITS) ||
                 (32'(cfg.data_bits) >= MAX_FRAME_BITS) ||
                 (32'(wsum) > MAX_FRAME_BITS);
      addr_over = (req.reg_addr >> cfg.addr_bits) != '0;
      val_over  = (req.mode == MODE_WRITE) && ((req.write_value >> cfg.data_bits) != '0);

      chk.refuse = too_wide || addr_over || val_over;
      if (too_wide) begin
         chk.status = ST_WIDTHS_BIG;
      end else if (addr_over) begin
         chk.status = ST_ADDR_WIDE;
      end else if (val_over) begin
         chk.status = ST_VALUE_WIDE;
      end else begin
         chk.status = ST_OK;
      end

      // read frame: flag bit above the address; write frame: address above data
      if (req.mode == MODE_READ) begin
         frame      = (SO_W'(1) << cfg.addr_bits) | SO_W'(req.reg_addr);
         frame_bits = BCNT_W'(cfg.addr_bits) + BCNT_W'(1);
      end else begin
         frame      = (SO_W'(req.reg_addr) << cfg.data_bits) | SO_W'(req.write_value);
         frame_bits = BCNT_W'(wsum) + BCNT_W'(1);
      end
   end

endmodule

FILE: rtl/tw3_seq.sv
module tw3_seq #(
   parameter int MAX_FRAME_BITS = tw3_pkg::MAX_FRAME_BITS_DEF,
   parameter int SO_W = MAX_FRAME_BITS + 1,
   parameter int BCNT_W = $clog2(MAX_FRAME_BITS + 2)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tw3_pkg::cfg_type    cfg,
   input  tw3_pkg::req_type    req,
   input  tw3_pkg::chk_type    chk,
   input  logic [SO_W-1:0]     frame,
   input  logic [BCNT_W-1:0]   frame_bits,
   output tw3_pkg::rsp_type    rsp
);
   import tw3_pkg::*;

   localparam int SIDX_W = $clog2(SO_W);

   phase_type         phase_ff, phase_in;
   logic [15:0]       tick_ff, tick_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic [SO_W-1:0]   sout_ff, sout_in;
   logic [VAL_W-1:0]  sin_ff, sin_in;
   logic              is_read_ff, is_read_in;

   logic              done;
   status_type        status;
   logic [VAL_W-1:0]  rdata;
   logic [15:0]       half;
   logic [15:0]       tick_dec;
   logic [BCNT_W-1:0] bdec;
   logic [VAL_W-1:0]  sin_sh;
   logic [VAL_W-1:0]  rmask;
   logic [BCNT_W-1:0] bidx;
   logic              cur_bit;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bcnt_in    = bcnt_ff;
      sout_in    = sout_ff;
      sin_in     = sin_ff;
      is_read_in = is_read_ff;
      done       = 1'b0;
      status     = ST_OK;
      rdata      = '0;
      half       = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
      tick_dec   = (tick_ff == '0) ? '0 : tick_ff - 16'd1;
      bdec       = (bcnt_ff == '0) ? '0 : bcnt_ff - BCNT_W'(1);
      sin_sh     = {sin_ff[VAL_W-2:0], req.line_in};
      rmask      = VAL_W'((33'd1 << cfg.data_bits) - 33'd1);

      case (phase_ff)
         PH_IDLE: begin
            if (req.start_req) begin
               if (chk.refuse) begin
                  done   = 1'b1;
                  status = chk.status;
               end else begin
                  is_read_in = req.mode;
                  sout_in    = frame;
                  bcnt_in    = frame_bits;
                  sin_in     = '0;
                  if (cfg.lead_ticks == '0) begin
                     phase_in = PH_DLO;
                     tick_in  = half;
                  end else begin
                     phase_in = PH_LEAD;
                     tick_in  = cfg.lead_ticks;
                  end
               end
            end
         end
         default: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               case (phase_ff)
                  PH_LEAD: begin
                     phase_in = PH_DLO;
                     tick_in  = half;
                  end
                  PH_DLO: begin
                     phase_in = PH_DHI;
                     tick_in  = half;
                  end
                  PH_DHI: begin
                     phase_in = PH_SLO;
                     tick_in  = half;
                  end
                  PH_SLO: begin
                     phase_in = PH_SHI;
                     tick_in  = half;
                  end
                  PH_SHI: begin
                     bcnt_in = bdec;
                     if (bdec != '0) begin
                        phase_in = PH_SLO;
                        tick_in  = half;
                     end else if (is_read_ff) begin
                        bcnt_in  = BCNT_W'(cfg.data_bits) + BCNT_W'(2);
                        sin_in   = '0;
                        phase_in = PH_RLO;
                        tick_in  = half;
                     end else begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_RLO: begin
                     phase_in = PH_RHI;
                     tick_in  = half;
                  end
                  PH_RHI: begin
                     sin_in  = sin_sh;
                     bcnt_in = bdec;
                     if (bdec != '0) begin
                        phase_in = PH_RLO;
                        tick_in  = half;
                     end else begin
                        rdata    = sin_sh & rmask;
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                        bcnt_in  = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   // pin levels follow the phase being entered
   always_comb begin
      bidx    = bcnt_in - BCNT_W'(1);
      cur_bit = (bcnt_in != '0) && sout_in[bidx[SIDX_W-1:0]];

      rsp.select_pin = 1'b0;
      rsp.clock_pin  = 1'b0;
      rsp.line_out   = 1'b0;
      rsp.line_drive = 1'b1;
      case (phase_in)
         PH_DHI: begin
            rsp.clock_pin = 1'b1;
         end
         PH_SLO: begin
            rsp.select_pin = 1'b1;
            rsp.line_out   = cur_bit;
         end
         PH_SHI: begin
            rsp.select_pin = 1'b1;
            rsp.clock_pin  = 1'b1;
            rsp.line_out   = cur_bit;
         end
         PH_RLO: begin
            rsp.line_drive = 1'b0;
         end
         PH_RHI: begin
            rsp.line_drive = 1'b0;
            rsp.clock_pin  = 1'b1;
         end
         default: begin
            rsp.line_drive = 1'b1;
         end
      endcase
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.status    = status;
      rsp.read_data = rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bcnt_ff    <= '0;
         is_read_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bcnt_ff    <= bcnt_in;
         is_read_ff <= is_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sout_ff <= sout_in;
         sin_ff  <= sin_in;
      end
   end

endmodule

FILE: rtl/three_wire_spi_register_master_unit.sv
// Three-wire serial register bus master, one transaction per timebase tick.
// req channel: each transaction is one tick carrying an optional request
//    (start_req, mode, reg_addr, write_value) and the sampled data line level.
// rsp channel: one transaction per tick with the pin levels after that tick,
//    busy, done, status and the read data on the done tick of a read.
// csr channel: register writes (address width, data width, half period,
//    lead ticks), always ready; write only while no frame is running.
// An accepted tick is held in the input register, then stepped through the
//    sequencer into the rsp register once rsp is empty or being drained.
// Throughput: one tick per cycle while rsp is not stalled.
// A refused request answers on its own tick with done and a nonzero status.
// A stalled rsp holds its transaction; the input register still takes one
//    more tick, then req_tready drops until rsp drains.
// Reset returns to idle with the line driven low and restores the register
//    defaults (8 address bits, 16 data bits, half period 1, lead 100).
module three_wire_spi_register_master_unit #(
   parameter int MAX_FRAME_BITS = tw3_pkg::MAX_FRAME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_req, mode, reg_addr[29:0], write_value[29:0], line_in, zero pad
   input  logic [tw3_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // select_pin, clock_pin, line_out, line_drive, busy_res, done_res,
   // status[1:0], read_data[29:0], zero pad
   output logic [tw3_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tw3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tw3_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tw3_pkg::*;

   localparam int SO_W = MAX_FRAME_BITS + 1;
   localparam int BCNT_W = $clog2(MAX_FRAME_BITS + 2);

   cfg_type           cfg_ff;
   req_type           in_ff;
   logic              in_valid_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic              step;
   chk_type           chk;
   rsp_type           rsp_next;
   logic [SO_W-1:0]   frame;
   logic [BCNT_W-1:0] frame_bits;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addr_bits         <= ADDR_WIDTH_RST;
         cfg_ff.data_bits         <= DATA_WIDTH_RST;
         cfg_ff.half_period_ticks <= HALF_TICKS_RST;
         cfg_ff.lead_ticks        <= LEAD_TICKS_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_ADDR_WIDTH: cfg_ff.addr_bits         <= csr_data[4:0];
            CSR_DATA_WIDTH: cfg_ff.data_bits         <= csr_data[4:0];
            CSR_HALF_TICKS: cfg_ff.half_period_ticks <= csr_data;
            CSR_LEAD_TICKS: cfg_ff.lead_ticks        <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.start_req   <= req_tdata[0];
         in_ff.mode        <= req_tdata[1];
         in_ff.reg_addr    <= req_tdata[VAL_W+1:2];
         in_ff.write_value <= req_tdata[2*VAL_W+1:VAL_W+2];
         in_ff.line_in     <= req_tdata[2*VAL_W+2];
      end
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   tw3_req_check #(
      .MAX_FRAME_BITS(MAX_FRAME_BITS),
      .SO_W(SO_W),
      .BCNT_W(BCNT_W)
   ) u_check (
      .cfg(cfg_ff),
      .req(in_ff),
      .chk(chk),
      .frame(frame),
      .frame_bits(frame_bits)
   );

   tw3_seq #(
      .MAX_FRAME_BITS(MAX_FRAME_BITS),
      .SO_W(SO_W),
      .BCNT_W(BCNT_W)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .step(step),
      .cfg(cfg_ff),
      .req(in_ff),
      .chk(chk),
      .frame(frame),
      .frame_bits(frame_bits),
      .rsp(rsp_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.read_data, rsp_ff.status, rsp_ff.done_res,
                        rsp_ff.busy_res, rsp_ff.line_drive, rsp_ff.line_out,
                        rsp_ff.clock_pin, rsp_ff.select_pin};

endmodule

FILE: rtl/tw3_checker.sv
`include "three_wire_spi_register_master_unit_defines.svh"

module tw3_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tw3_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import tw3_pkg::*;

   logic             sel, dat, drv, busy, done;
   logic [1:0]       stat;
   logic [VAL_W-1:0] rdat;

   assign sel  = rsp_tdata[0];
   assign dat  = rsp_tdata[2];
   assign drv  = rsp_tdata[3];
   assign busy = rsp_tdata[4];
   assign done = rsp_tdata[5];
   assign stat = rsp_tdata[7:6];
   assign rdat = rsp_tdata[VAL_W+7:8];

   // a stalled result transaction keeps its contents
   `TW3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // the finishing tick is never busy
   `TW3_ASSERT_NOW(a_done_idle, clock, reset, rsp_tvalid && done, !busy)

   // a refusal status only appears with done
   `TW3_ASSERT_NOW(a_status_done, clock, reset, rsp_tvalid && stat != ST_OK, done)

   // released line: select low, no data driven, sequencer busy
   `TW3_ASSERT_NOW(a_release, clock, reset, rsp_tvalid && !drv, !sel && !dat && busy)

   // read data only on the done tick
   `TW3_ASSERT_NOW(a_rdata_done, clock, reset, rsp_tvalid && rdat != '0, done)

endmodule

bind three_wire_spi_register_master_unit tw3_checker u_tw3_checker (.*);

FILE: tb/sv/three_wire_spi_register_master_unit_test.sv
`timescale 1ns / 100ps

module three_wire_spi_register_master_unit_test;
   import tw3_pkg::*;

   localparam int FRAME_BITS_MAX = MAX_FRAME_BITS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 5;
   localparam int TICKS_PER_PHASE = 70;

   typedef struct {
      csr_idx_type index;
      logic [15:0] value;
   } reg_write_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_idx_type            csr_index = CSR_ADDR_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   req_type shown_tick = '0;

   // register copy and sequencer state of the prediction
   logic [4:0]  cfg_aw = ADDR_WIDTH_RST;
   logic [4:0]  cfg_dw = DATA_WIDTH_RST;
   logic [15:0] cfg_half = HALF_TICKS_RST;
   logic [15:0] cfg_lead = LEAD_TICKS_RST;
   phase_type   seq_phase = PH_IDLE;
   logic [15:0] seq_ticks = '0;
   logic [5:0]  seq_bits = '0;
   logic [63:0] seq_out = '0;
   logic [63:0] seq_in = '0;
   logic        seq_read = 1'b0;
   logic        pin_sel = 1'b0;
   logic        pin_clk = 1'b0;
   logic        pin_dat = 1'b0;
   logic        pin_drv = 1'b1;

   req_type       tick_queue[$];
   rsp_type       expected_levels[$];
   reg_write_type reg_writes[$];

   int ticks_queued = 0;
   int results_checked = 0;
   int regs_written = 0;
   int fail_count = 0;
   int frames_done = 0;
   int refusals = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int quiet_cycles = 0;
   bit steady = 1'b0;

   // start_req, mode, reg_addr[29:0], write_value[29:0], line_in, zero pad
   assign req_tdata = {1'b0, shown_tick.line_in, shown_tick.write_value,
                       shown_tick.reg_addr, shown_tick.mode, shown_tick.start_req};

   three_wire_spi_register_master_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] half_ticks();
      return (cfg_half == 16'd0) ? 16'd1 : cfg_half;
   endfunction

   function automatic logic [63:0] low_mask(int width);
      return (64'd1 << width) - 64'd1;
   endfunction

   function automatic void set_pins(logic sel, logic clk, logic dat, logic drv);
      pin_sel = sel;
      pin_clk = clk;
      pin_dat = dat;
      pin_drv = drv;
   endfunction

   function automatic void enter_phase(phase_type target);
      phase_type p;
      logic      bit_now;
      p = target;
      if (p == PH_LEAD && cfg_lead == 16'd0)
         p = PH_DLO;
      bit_now = (seq_bits == 6'd0) ? 1'b0 : seq_out[seq_bits - 6'd1];
      seq_phase = p;
      seq_ticks = (p == PH_LEAD) ? cfg_lead : half_ticks();
      case (p)
         PH_LEAD, PH_DLO: set_pins(1'b0, 1'b0, 1'b0, 1'b1);
         PH_DHI: set_pins(1'b0, 1'b1, 1'b0, 1'b1);
         PH_SLO: set_pins(1'b1, 1'b0, bit_now, 1'b1);
         PH_SHI: set_pins(1'b1, 1'b1, bit_now, 1'b1);
         PH_RLO: set_pins(1'b0, 1'b0, 1'b0, 1'b0);
         PH_RHI: set_pins(1'b0, 1'b1, 1'b0, 1'b0);
         default: begin
            set_pins(1'b0, 1'b0, 1'b0, 1'b1);
            seq_ticks = '0;
         end
      endcase
   endfunction

   // one timebase tick through the pin sequencer; returns the levels after it
   function automatic rsp_type step_sequencer(req_type t);
      rsp_type     r;
      status_type  refusal;
      logic        done;
      logic        finish;
      logic [63:0] rdata;
      refusal = ST_OK;
      done = 1'b0;
      finish = 1'b0;
      rdata = '0;
      if (seq_phase == PH_IDLE) begin
         set_pins(1'b0, 1'b0, 1'b0, 1'b1);
         if (t.start_req) begin
            if (cfg_aw >= FRAME_BITS_MAX || cfg_dw >= FRAME_BITS_MAX
                || int'(cfg_aw) + int'(cfg_dw) > FRAME_BITS_MAX) begin
               refusal = ST_WIDTHS_BIG;
            end else if (64'(t.reg_addr) > low_mask(cfg_aw)) begin
               refusal = ST_ADDR_WIDE;
            end else if (t.mode == MODE_WRITE && 64'(t.write_value) > low_mask(cfg_dw)) begin
               refusal = ST_VALUE_WIDE;
            end else begin
               seq_read = (t.mode == MODE_READ);
               if (seq_read) begin
                  seq_out = (64'd1 << cfg_aw) | 64'(t.reg_addr);
                  seq_bits = 6'(cfg_aw) + 6'd1;
               end else begin
                  seq_out = (64'(t.reg_addr) << cfg_dw) | 64'(t.write_value);
                  seq_bits = 6'(cfg_aw) + 6'(cfg_dw) + 6'd1;
               end
               seq_in = '0;
               enter_phase(PH_LEAD);
            end
            done = (refusal != ST_OK);
         end
      end else begin
         if (seq_ticks != 16'd0)
            seq_ticks = seq_ticks - 16'd1;
         if (seq_ticks == 16'd0) begin
            case (seq_phase)
               PH_LEAD: enter_phase(PH_DLO);
               PH_DLO: enter_phase(PH_DHI);
               PH_DHI: enter_phase(PH_SLO);
               PH_SLO: enter_phase(PH_SHI);
               PH_SHI: begin
                  if (seq_bits != 6'd0)
                     seq_bits = seq_bits - 6'd1;
                  if (seq_bits != 6'd0) begin
                     enter_phase(PH_SLO);
                  end else if (seq_read) begin
                     // two turnaround bits lead the returned data
                     seq_bits = 6'(cfg_dw) + 6'd2;
                     seq_in = '0;
                     enter_phase(PH_RLO);
                  end else begin
                     finish = 1'b1;
                  end
               end
               PH_RLO: enter_phase(PH_RHI);
               default: begin
                  seq_in = {seq_in[62:0], t.line_in} & low_mask(40);
                  if (seq_bits != 6'd0)
                     seq_bits = seq_bits - 6'd1;
                  if (seq_bits != 6'd0) begin
                     enter_phase(PH_RLO);
                  end else begin
                     rdata = seq_in & low_mask(cfg_dw);
                     finish = 1'b1;
                  end
               end
            endcase
            if (finish) begin
               done = 1'b1;
               seq_phase = PH_IDLE;
               set_pins(1'b0, 1'b0, 1'b0, 1'b1);
               seq_bits = '0;
            end
         end
      end
      r.select_pin = pin_sel;
      r.clock_pin = pin_clk;
      r.line_out = pin_dat;
      r.line_drive = pin_drv;
      r.busy_res = (seq_phase != PH_IDLE);
      r.done_res = done;
      r.status = refusal;
      r.read_data = rdata[29:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [29:0] want, logic [29:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // mostly in range for the current width, now and then any 30-bit value
   function automatic logic [29:0] random_field(int width);
      if ($urandom_range(0, 9) == 0)
         return 30'($urandom);
      return 30'(64'($urandom) & low_mask(width));
   endfunction

   task automatic wait_drain();
      while (results_checked != ticks_queued)
         @(posedge clock);
   endtask

   task automatic queue_tick(req_type t);
      while (tick_queue.size() >= 32)
         @(posedge clock);
      tick_queue.push_back(t);
      ticks_queued++;
   endtask

   task automatic queue_request(mode_type mode, logic [29:0] addr, logic [29:0] value);
      req_type t;
      t.start_req = 1'b1;
      t.mode = mode;
      t.reg_addr = addr;
      t.write_value = value;
      t.line_in = $urandom_range(0, 1);
      queue_tick(t);
   endtask

   task automatic queue_idle(int count);
      req_type t;
      repeat (count) begin
         t.start_req = 1'b0;
         t.mode = $urandom_range(0, 1);
         t.reg_addr = 30'($urandom);
         t.write_value = 30'($urandom);
         t.line_in = $urandom_range(0, 1);
         queue_tick(t);
      end
   endtask

   task automatic random_ticks(int count);
      req_type t;
      repeat (count) begin
         t.start_req = ($urandom_range(0, 2) == 0);
         t.mode = $urandom_range(0, 1);
         t.reg_addr = random_field(cfg_aw);
         t.write_value = random_field(cfg_dw);
         t.line_in = $urandom_range(0, 1);
         queue_tick(t);
      end
   endtask

   // feed quiet ticks until the sequencer is back in idle
   task automatic settle();
      int chunk;
      wait_drain();
      while (seq_phase != PH_IDLE) begin
         chunk = int'(seq_ticks) + 2 * int'(half_ticks()) * int'(seq_bits);
         queue_idle(chunk);
         wait_drain();
      end
   endtask

   task automatic set_reg(csr_idx_type index, logic [15:0] value);
      reg_write_type w;
      int            target;
      wait_drain();
      repeat (4) @(posedge clock);
      w.index = index;
      w.value = value;
      target = regs_written + 1;
      reg_writes.push_back(w);
      while (regs_written != target)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : tick_driver
      rsp_type predicted;
      logic    present;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = step_sequencer(shown_tick);
            expected_levels.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            present = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (!steady && $urandom_range(0, 15) == 0) begin
               req_gap = $urandom_range(0, 6);
            end else if (tick_queue.size() > 0) begin
               shown_tick <= tick_queue.pop_front();
               present = 1'b1;
            end
            req_tvalid <= present;
         end
      end
   end

   always @(posedge clock) begin : reg_driver
      reg_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ADDR_WIDTH: cfg_aw = csr_data[4:0];
               CSR_DATA_WIDTH: cfg_dw = csr_data[4:0];
               CSR_HALF_TICKS: cfg_half = csr_data;
               CSR_LEAD_TICKS: cfg_lead = csr_data;
               default: ;
            endcase
            regs_written++;
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes.size() > 0) begin
               w = reg_writes.pop_front();
               csr_index <= w.index;
               csr_data <= w.value;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : level_monitor
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            // select, clock, line out, drive, busy, done, status[1:0], read data[29:0]
            seen.select_pin = rsp_tdata[0];
            seen.clock_pin = rsp_tdata[1];
            seen.line_out = rsp_tdata[2];
            seen.line_drive = rsp_tdata[3];
            seen.busy_res = rsp_tdata[4];
            seen.done_res = rsp_tdata[5];
            seen.status = status_type'(rsp_tdata[7:6]);
            seen.read_data = rsp_tdata[37:8];
            if (expected_levels.size() == 0) begin
               $error("transaction with no tick pending: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_levels.pop_front();
               check_field("select_pin", want.select_pin, seen.select_pin);
               check_field("clock_pin", want.clock_pin, seen.clock_pin);
               check_field("line_out", want.line_out, seen.line_out);
               check_field("line_drive", want.line_drive, seen.line_drive);
               check_field("busy_res", want.busy_res, seen.busy_res);
               check_field("done_res", want.done_res, seen.done_res);
               check_field("status", want.status, seen.status);
               check_field("read_data", want.read_data, seen.read_data);
               if (want.done_res && want.status == ST_OK)
                  frames_done++;
               else if (want.done_res)
                  refusals++;
            end
            results_checked++;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 11) == 0) begin
            rsp_gap = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL three_wire_spi_register_master_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          n;
      logic [4:0]  aw;
      logic [4:0]  dw;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset widths: 8 address bits, 16 data bits, lead 100, half period 1
      queue_request(MODE_WRITE, 30'hFF, 30'hFFFF);
      queue_request(MODE_READ, 30'h3FFF_FFFF, 30'h0);   // lands in the lead, ignored
      settle();
      queue_request(MODE_READ, 30'hA5, 30'h3FFF_FFFF);
      settle();
      queue_request(MODE_WRITE, 30'h100, 30'h0);
      settle();
      queue_request(MODE_WRITE, 30'h0, 30'h10000);
      settle();
      queue_request(MODE_READ, 30'h3FFF_FFFF, 30'h0);
      settle();
      // zero half period acts as one, zero lead skips straight to the dummy clock
      set_reg(CSR_HALF_TICKS, 16'd0);
      set_reg(CSR_LEAD_TICKS, 16'd0);
      queue_request(MODE_WRITE, 30'h5A, 30'hA5A5);
      settle();
      queue_request(MODE_READ, 30'h0, 30'h0);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd31);
      queue_request(MODE_WRITE, 30'h0, 30'h0);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd0);
      set_reg(CSR_DATA_WIDTH, 16'd31);
      queue_request(MODE_READ, 30'h0, 30'h0);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd16);
      set_reg(CSR_DATA_WIDTH, 16'd16);
      queue_request(MODE_WRITE, 30'h0, 30'h0);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd30);
      set_reg(CSR_DATA_WIDTH, 16'd1);
      queue_request(MODE_WRITE, 30'h3FFF_FFFF, 30'h1);
      settle();
      queue_request(MODE_READ, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd1);
      set_reg(CSR_DATA_WIDTH, 16'd30);
      queue_request(MODE_WRITE, 30'h1, 30'h3FFF_FFFF);
      settle();
      queue_request(MODE_READ, 30'h0, 30'h0);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd0);
      set_reg(CSR_DATA_WIDTH, 16'd0);
      queue_request(MODE_WRITE, 30'h0, 30'h0);
      settle();
      queue_request(MODE_READ, 30'h0, 30'h0);
      settle();
      queue_request(MODE_WRITE, 30'h1, 30'h0);
      settle();
      queue_request(MODE_WRITE, 30'h0, 30'h1);
      settle();

      for (n = 0; n < RANDOM_PHASES; n++) begin
         aw = $urandom_range(0, 10);
         dw = $urandom_range(0, 16);
         if ($urandom_range(0, 5) == 0) begin
            aw = $urandom_range(0, 31);
            dw = $urandom_range(0, 31);
         end
         // upper bits of a width write are don't-care
         set_reg(CSR_ADDR_WIDTH, {11'($urandom), aw});
         set_reg(CSR_DATA_WIDTH, {11'($urandom), dw});
         set_reg(CSR_HALF_TICKS, 16'($urandom_range(0, 3)));
         set_reg(CSR_LEAD_TICKS, 16'($urandom_range(0, 5)));
         random_ticks(TICKS_PER_PHASE);
         settle();
      end

      // closing stretch without stalls, including long segments
      steady = 1'b1;
      set_reg(CSR_ADDR_WIDTH, 16'd6);
      set_reg(CSR_DATA_WIDTH, 16'd10);
      set_reg(CSR_HALF_TICKS, 16'd1);
      set_reg(CSR_LEAD_TICKS, 16'd2);
      random_ticks(TICKS_PER_PHASE);
      settle();
      set_reg(CSR_HALF_TICKS, 16'd0);
      set_reg(CSR_LEAD_TICKS, 16'd200);
      queue_request(MODE_READ, 30'h2A, 30'h0);
      settle();
      set_reg(CSR_ADDR_WIDTH, 16'd0);
      set_reg(CSR_DATA_WIDTH, 16'd0);
      set_reg(CSR_LEAD_TICKS, 16'd0);
      set_reg(CSR_HALF_TICKS, 16'd25);
      queue_request(MODE_WRITE, 30'h0, 30'h0);
      settle();

      repeat (8) @(posedge clock);
      if (expected_levels.size() != 0) begin
         $error("%0d expected transactions never arrived", expected_levels.size());
         fail_count++;
      end
      $display("Checked %0d ticks: %0d frames completed, %0d requests refused.",
               results_checked, frames_done, refusals);
      $display("Widths 0 to 31, half periods up to 25 ticks and leads up to 200 were used.");
      if (fail_count == 0) begin
         $display("PASS three_wire_spi_register_master_unit");
      end else begin
         $display("FAIL three_wire_spi_register_master_unit");
      end
      $finish;
   end

endmodule
